@@ hdl/mte_pkg.sv @@
// ----------------------------------------------------------------------------
// mte_pkg: shared types and codes for the 4x4 matrix transform engine
// Command and response item layouts, function codes and matrix geometry.
// ----------------------------------------------------------------------------
package mte_pkg;

    // Matrix geometry (fixed by the 4-component vector and 4-bit indexes)
    localparam int DIM    = 4;
    localparam int NCELL  = DIM * DIM;
    localparam int IDX_W  = $clog2(DIM);
    localparam int CELL_W = $clog2(NCELL);
    localparam int WORD_W = 32;

    // Function codes
    localparam logic [2:0] FUNC_LOAD_A = 3'd0;
    localparam logic [2:0] FUNC_LOAD_B = 3'd1;
    localparam logic [2:0] FUNC_XFORM  = 3'd2;
    localparam logic [2:0] FUNC_MUL    = 3'd3;
    localparam logic [2:0] FUNC_ADD    = 3'd4;

    typedef struct packed {
        logic [2:0]               func;
        logic [3:0]               elem_index;
        logic signed [WORD_W-1:0] elem_value;
        logic signed [WORD_W-1:0] vec_x;
        logic signed [WORD_W-1:0] vec_y;
        logic signed [WORD_W-1:0] vec_z;
        logic signed [WORD_W-1:0] vec_w;
    } cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] res0;
        logic signed [WORD_W-1:0] res1;
        logic signed [WORD_W-1:0] res2;
        logic signed [WORD_W-1:0] res3;
        logic [3:0]               out_index;
        logic                     last;
        logic                     saturated;
    } rsp_t;

endpackage

@@ hdl/matrix4_transform_engine.sv @@
// ----------------------------------------------------------------------------
// matrix4_transform_engine: 4x4 Q16.16 matrix / vector engine
// Two matrix stores A and B; transform (A*v), multiply (A*B) and add (A+B)
// on one shared 32x32 multiplier (not used by add) and accumulator under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  cmd     | in  | cmd_valid/cmd_stall| mte_pkg::cmd_t (func, index, values)
//  rsp     | out | rsp_valid/rsp_stall| mte_pkg::rsp_t (results, index, flags)
//
//  Loads finish in the accept cycle; cmd_stall stays low while idle.
//  Transform: 4 rows, each of 4 multiply steps, a drain and a round, then
//  one result item. Multiply: 4 multiply steps, a drain, a round and one
//  output item per element. Add: an add, a round and one output item per
//  element. The single multiplier does one MAC per cycle while multiplying.
//  cmd_stall is high from accept of a compute item until its last result
//  item is taken; rsp_stall only holds the sequencer in its output state.
//  Reset clears the sequencer and both matrix stores to zero.
//
module matrix4_transform_engine #(
    parameter int FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  mte_pkg::cmd_t  cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mte_pkg::rsp_t  rsp
);

    localparam int DIM    = mte_pkg::DIM;
    localparam int NCELL  = mte_pkg::NCELL;
    localparam int IDX_W  = mte_pkg::IDX_W;
    localparam int CELL_W = mte_pkg::CELL_W;
    localparam int WORD_W = mte_pkg::WORD_W;
    localparam int PROD_W = 2 * WORD_W;
    // full-width sum of DIM products
    localparam int ACC_W  = PROD_W + $clog2(DIM) + 1;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);
    localparam logic signed [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_RND   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // control
    logic [2:0]       state_reg, state_next;
    logic [2:0]       func_reg, func_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             pv_reg, pv_next;
    logic             sat_reg, sat_next;
    logic             last_reg, last_next;
    logic [3:0]       oidx_reg, oidx_next;

    // storage
    logic signed [WORD_W-1:0] mat_a_reg [NCELL];
    logic signed [WORD_W-1:0] mat_b_reg [NCELL];

    // datapath (no reset)
    logic signed [WORD_W-1:0] vec_reg  [DIM];
    logic signed [WORD_W-1:0] comp_reg [DIM];
    logic signed [WORD_W-1:0] row_reg  [DIM];
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic cmd_acc, rsp_acc;
    logic is_xform, is_add;
    logic load_a_en, load_b_en, idx_ok;
    logic wb_en, comp_en, row_en, start_en;

    logic [IDX_W-1:0]         a_col, b_row;
    logic signed [WORD_W-1:0] a_op, b_op;
    logic signed [ACC_W-1:0]  acc_sh;
    logic                     rnd_ovf;
    logic signed [WORD_W-1:0] rnd_val;

    assign cmd_acc  = cmd_valid && !cmd_stall;
    assign rsp_acc  = rsp_valid && !rsp_stall;
    assign is_xform = (func_reg == mte_pkg::FUNC_XFORM);
    assign is_add   = (func_reg == mte_pkg::FUNC_ADD);

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);

    assign rsp.res0      = comp_reg[0];
    assign rsp.res1      = comp_reg[1];
    assign rsp.res2      = comp_reg[2];
    assign rsp.res3      = comp_reg[3];
    assign rsp.out_index = oidx_reg;
    assign rsp.last      = last_reg;
    assign rsp.saturated = sat_reg;

    // loads beyond the store are dropped
    assign idx_ok    = ({1'b0, cmd.elem_index} < 5'(NCELL));
    assign load_a_en = cmd_acc && idx_ok && (cmd.func == mte_pkg::FUNC_LOAD_A);
    assign load_b_en = cmd_acc && idx_ok && (cmd.func == mte_pkg::FUNC_LOAD_B);
    assign start_en  = cmd_acc && ((cmd.func == mte_pkg::FUNC_XFORM) ||
                                   (cmd.func == mte_pkg::FUNC_MUL)   ||
                                   (cmd.func == mte_pkg::FUNC_ADD));

    // operand select: add walks A[i][j]+B[i][j], products walk k
    assign a_col = is_add ? j_reg : k_reg;
    assign b_row = is_add ? i_reg : k_reg;
    assign a_op  = mat_a_reg[{i_reg, a_col}];
    assign b_op  = is_xform ? vec_reg[k_reg] : mat_b_reg[{b_row, j_reg}];

    assign prod_next = PROD_W'(a_op) * PROD_W'(b_op);

    // floor shift then clamp to a signed word
    assign acc_sh  = acc_reg >>> FRAC_BITS;
    assign rnd_ovf = !((&acc_sh[ACC_W-1:WORD_W-1]) || !(|acc_sh[ACC_W-1:WORD_W-1]));
    assign rnd_val = rnd_ovf ? (acc_sh[ACC_W-1] ? SAT_MIN : SAT_MAX)
                             : acc_sh[WORD_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        pv_next    = pv_reg;
        sat_next   = sat_reg;
        last_next  = last_reg;
        oidx_next  = oidx_reg;
        acc_next   = acc_reg;
        wb_en      = 1'b0;
        comp_en    = 1'b0;
        row_en     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start_en)
                begin
                    func_next  = cmd.func;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    pv_next    = 1'b0;
                    sat_next   = 1'b0;
                    acc_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (is_add)
                begin
                    acc_next   = (ACC_W'(a_op) + ACC_W'(b_op)) <<< FRAC_BITS;
                    state_next = S_RND;
                end
                else
                begin
                    pv_next  = 1'b1;
                    acc_next = pv_reg ? acc_reg + ACC_W'(prod_reg) : acc_reg;
                    if (k_reg == IDX_LAST)
                        state_next = S_DRAIN;
                    else
                        k_next = k_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                pv_next    = 1'b0;
                state_next = S_RND;
            end
            S_RND:
            begin
                comp_en = 1'b1;
                if (is_xform)
                begin
                    sat_next = sat_reg | rnd_ovf;
                    if (i_reg == IDX_LAST)
                    begin
                        last_next  = 1'b1;
                        oidx_next  = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        k_next     = '0;
                        acc_next   = '0;
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    row_en     = 1'b1;
                    sat_next   = rnd_ovf;
                    oidx_next  = 4'({i_reg, j_reg});
                    last_next  = (i_reg == IDX_LAST) && (j_reg == IDX_LAST);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (rsp_acc)
                begin
                    if (is_xform || last_reg)
                        state_next = S_IDLE;
                    else
                        state_next = S_MUL;
                    if (!is_xform)
                    begin
                        // row is complete: A row i no longer needed
                        wb_en = (j_reg == IDX_LAST);
                        if (j_reg == IDX_LAST)
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        else
                            j_next = j_reg + 1'b1;
                        k_next   = '0;
                        acc_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            func_reg  <= mte_pkg::FUNC_LOAD_A;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            pv_reg    <= 1'b0;
            sat_reg   <= 1'b0;
            last_reg  <= 1'b0;
            oidx_reg  <= '0;
            for (int n = 0; n < NCELL; n++)
            begin
                mat_a_reg[n] <= '0;
                mat_b_reg[n] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            func_reg  <= func_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            pv_reg    <= pv_next;
            sat_reg   <= sat_next;
            last_reg  <= last_next;
            oidx_reg  <= oidx_next;
            if (load_a_en)
                mat_a_reg[cmd.elem_index[CELL_W-1:0]] <= cmd.elem_value;
            if (load_b_en)
                mat_b_reg[cmd.elem_index[CELL_W-1:0]] <= cmd.elem_value;
            if (wb_en)
            begin
                for (int c = 0; c < DIM; c++)
                    mat_a_reg[{i_reg, IDX_W'(c)}] <= row_reg[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (start_en)
        begin
            vec_reg[0] <= cmd.vec_x;
            vec_reg[1] <= cmd.vec_y;
            vec_reg[2] <= cmd.vec_z;
            vec_reg[3] <= cmd.vec_w;
            for (int c = 0; c < DIM; c++)
                comp_reg[c] <= '0;
        end
        if (comp_en)
        begin
            if (is_xform)
                comp_reg[i_reg] <= rnd_val;
            else
                comp_reg[0] <= rnd_val;
        end
        if (row_en)
            row_reg[j_reg] <= rnd_val;
    end

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_busy_while_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> cmd_stall)
        else $error("result pending while command side is open");

    a_xform_single: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && is_xform) |-> (rsp.last && (rsp.out_index == 4'd0)))
        else $error("transform result must be a single last item at index 0");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_acc && rsp.last) |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after last item");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !is_xform && rsp.last) |-> (rsp.out_index == 4'(NCELL - 1)))
        else $error("last matrix item not at final index");

    a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pv_reg)
        else $error("product pending while idle");

endmodule
